// ===== src/jts_pkg.sv =====
// Shared types, character codes and helper functions for the JSON token serializer.
package jts_pkg;

    typedef enum logic [3:0] {
        OP_BEGIN_OBJ = 4'd0,
        OP_END_OBJ   = 4'd1,
        OP_BEGIN_ARR = 4'd2,
        OP_END_ARR   = 4'd3,
        OP_KEY_CHAR  = 4'd4,
        OP_STR_CHAR  = 4'd5,
        OP_RAW_CHAR  = 4'd6,
        OP_BOOL      = 4'd7,
        OP_NULL      = 4'd8,
        OP_UNSIGNED  = 4'd9,
        OP_SIGNED    = 4'd10,
        OP_RESET     = 4'd11
    } op_t;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_OPEN,
        CMD_CLOSE,
        CMD_TEXT,
        CMD_RAW,
        CMD_LIT,
        CMD_NUM,
        CMD_RST
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        is_obj;
        logic        is_key;
        logic        first;
        logic        last;
        logic        has;
        logic        neg;
        logic [2:0]  body_len;
        logic [47:0] body;
        logic [63:0] mag;
    } cmd_t;

    typedef struct packed {
        logic [31:0] req;
        logic        ovf;
        logic [15:0] pos;
        logic        stored;
        logic        valid;
        logic [7:0]  ch;
    } res_t;

    typedef struct packed {
        logic [2:0]  len;
        logic [47:0] bytes;
    } esc_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEP,
        ST_HEAD,
        ST_BODY,
        ST_TAIL,
        ST_COLON,
        ST_CONV,
        ST_SKIP,
        ST_DIGIT,
        ST_END
    } state_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HEX_A  = 8'h57;  // 'a' - 10
    localparam logic [15:0] CAP_RESET = 16'd4096;
    localparam int DIGITS = 20;

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10)
            r = CH_ZERO + {4'h0, n};
        else
            r = CH_HEX_A + {4'h0, n};
        return r;
    endfunction

    function automatic esc_t escape(input logic [7:0] c);
        esc_t r;
        r.len   = 3'd2;
        r.bytes = 48'h0;
        case (c)
            8'h22: r.bytes[15:0] = {CH_QUOTE, CH_BSLASH};
            8'h5C: r.bytes[15:0] = {CH_BSLASH, CH_BSLASH};
            8'h0A: r.bytes[15:0] = {8'h6E, CH_BSLASH};
            8'h0D: r.bytes[15:0] = {8'h72, CH_BSLASH};
            8'h09: r.bytes[15:0] = {8'h74, CH_BSLASH};
            8'h08: r.bytes[15:0] = {8'h62, CH_BSLASH};
            8'h0C: r.bytes[15:0] = {8'h66, CH_BSLASH};
            default:
            begin
                if (c < CH_SPACE)
                begin
                    r.len   = 3'd6;
                    r.bytes = {hex_char(c[3:0]), hex_char(c[7:4]), CH_ZERO, CH_ZERO,
                               8'h75, CH_BSLASH};
                end
                else
                begin
                    r.len   = 3'd1;
                    r.bytes = {40'h0, c};
                end
            end
        endcase
        return r;
    endfunction

endpackage

// ===== src/jts_front.sv =====
// Front end: accepts token requests and classifies them into commands for the queue.
module jts_front (
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [3:0]    op,
    input  logic [7:0]    data_byte,
    input  logic          has_char,
    input  logic          first_char,
    input  logic          last_char,
    input  logic          flag_value,
    input  logic [63:0]   number,
    input  logic          q_full,
    output logic          push,
    output jts_pkg::cmd_t cmd
);

    jts_pkg::esc_t esc;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;
    assign esc      = jts_pkg::escape(data_byte);

    always_comb
    begin
        cmd          = '0;
        cmd.kind     = jts_pkg::CMD_NOP;
        cmd.first    = first_char;
        cmd.last     = last_char;
        cmd.has      = has_char;
        cmd.mag      = number;
        case (jts_pkg::op_t'(op))
            jts_pkg::OP_BEGIN_OBJ:
            begin
                cmd.kind   = jts_pkg::CMD_OPEN;
                cmd.is_obj = 1'b1;
            end
            jts_pkg::OP_END_OBJ:
            begin
                cmd.kind   = jts_pkg::CMD_CLOSE;
                cmd.is_obj = 1'b1;
            end
            jts_pkg::OP_BEGIN_ARR: cmd.kind = jts_pkg::CMD_OPEN;
            jts_pkg::OP_END_ARR:   cmd.kind = jts_pkg::CMD_CLOSE;
            jts_pkg::OP_KEY_CHAR, jts_pkg::OP_STR_CHAR:
            begin
                cmd.kind     = jts_pkg::CMD_TEXT;
                cmd.is_key   = (jts_pkg::op_t'(op) == jts_pkg::OP_KEY_CHAR);
                cmd.body_len = esc.len;
                cmd.body     = esc.bytes;
            end
            jts_pkg::OP_RAW_CHAR:
            begin
                cmd.kind     = jts_pkg::CMD_RAW;
                cmd.body_len = 3'd1;
                cmd.body     = {40'h0, data_byte};
            end
            jts_pkg::OP_BOOL:
            begin
                cmd.kind = jts_pkg::CMD_LIT;
                if (flag_value)
                begin
                    cmd.body_len = 3'd4;
                    cmd.body     = {16'h0, 8'h65, 8'h75, 8'h72, 8'h74};
                end
                else
                begin
                    cmd.body_len = 3'd5;
                    cmd.body     = {8'h0, 8'h65, 8'h73, 8'h6C, 8'h61, 8'h66};
                end
            end
            jts_pkg::OP_NULL:
            begin
                cmd.kind     = jts_pkg::CMD_LIT;
                cmd.body_len = 3'd4;
                cmd.body     = {16'h0, 8'h6C, 8'h6C, 8'h75, 8'h6E};
            end
            jts_pkg::OP_UNSIGNED: cmd.kind = jts_pkg::CMD_NUM;
            jts_pkg::OP_SIGNED:
            begin
                cmd.kind = jts_pkg::CMD_NUM;
                cmd.neg  = number[63];
                if (number[63])
                    cmd.mag = ~number + 64'd1;
            end
            jts_pkg::OP_RESET: cmd.kind = jts_pkg::CMD_RST;
            default: cmd.kind = jts_pkg::CMD_NOP;
        endcase
    end

endmodule

// ===== src/jts_queue.sv =====
// Four-entry command queue between front and back.
module jts_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  jts_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output jts_pkg::cmd_t pop_data
);

    jts_pkg::cmd_t mem [4];
    logic [2:0] wr_reg;
    logic [2:0] rd_reg;

    assign full     = (wr_reg[1:0] == rd_reg[1:0]) && (wr_reg[2] != rd_reg[2]);
    assign valid    = (wr_reg != rd_reg);
    assign pop_data = mem[rd_reg[1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= 3'd0;
            rd_reg <= 3'd0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 3'd1;
            if (pop)
                rd_reg <= rd_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg[1:0]] <= push_data;
    end

endmodule

// ===== src/jts_back.sv =====
// Back end: runs one command at a time, emits characters and keeps the writer state.
module jts_back #(
    parameter int MAX_DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [15:0]   capacity,
    input  logic          q_valid,
    input  jts_pkg::cmd_t q_data,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output jts_pkg::res_t out_res,
    output logic          out_last
);

    localparam int DEPW = $clog2(MAX_DEPTH + 1);
    localparam int SIW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    jts_pkg::state_t state_reg, state_next;
    jts_pkg::cmd_t   cmd_reg, cmd_next;
    logic [2:0]      idx_reg, idx_next;
    logic [79:0]     bcd_reg, bcd_next;
    logic [63:0]     bin_reg, bin_next;
    logic [5:0]      cnt_reg, cnt_next;
    logic [4:0]      dleft_reg, dleft_next;
    logic            hold_valid_reg, hold_valid_next;
    jts_pkg::res_t   hold_reg, hold_next;
    logic [15:0]     stored_reg, stored_next;
    logic [31:0]     req_reg, req_next;
    logic            ovf_reg, ovf_next;
    logic            comma_reg, comma_next;
    logic [DEPW-1:0] depth_reg, depth_next;
    logic [MAX_DEPTH-1:0] stack_reg, stack_next;
    logic            out_valid_reg, out_valid_next;
    jts_pkg::res_t   out_reg, out_next;
    logic            out_last_reg, out_last_next;

    logic            out_free;
    logic            emit_req;
    logic [7:0]      emit_ch;
    logic            advance;
    logic            sep_needed;
    logic            body_go;
    logic            too_deep;
    logic            bad_close;
    logic [79:0]     bcd_adj;
    logic [SIW-1:0]  top_idx;
    logic            emit_ok;
    jts_pkg::res_t   new_res;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;
    assign out_last  = out_last_reg;

    assign top_idx    = SIW'(depth_reg - DEPW'(1));
    assign too_deep   = (depth_reg >= DEPW'(MAX_DEPTH));
    assign bad_close  = (depth_reg == '0) || (stack_reg[top_idx] != cmd_reg.is_obj);
    assign sep_needed = (cmd_reg.kind == jts_pkg::CMD_OPEN) || (cmd_reg.kind == jts_pkg::CMD_LIT)
                     || (cmd_reg.kind == jts_pkg::CMD_NUM)
                     || (((cmd_reg.kind == jts_pkg::CMD_TEXT) || (cmd_reg.kind == jts_pkg::CMD_RAW))
                         && cmd_reg.first);
    assign body_go    = (cmd_reg.kind == jts_pkg::CMD_LIT)
                     || (((cmd_reg.kind == jts_pkg::CMD_TEXT) || (cmd_reg.kind == jts_pkg::CMD_RAW))
                         && cmd_reg.has);

    // Double dabble correction on every digit.
    always_comb
    begin
        for (int i = 0; i < jts_pkg::DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    // Character that the current step wants to emit.
    always_comb
    begin
        emit_req = 1'b0;
        emit_ch  = jts_pkg::CH_COMMA;
        case (state_reg)
            jts_pkg::ST_SEP:
            begin
                emit_req = sep_needed && comma_reg;
            end
            jts_pkg::ST_HEAD:
            begin
                case (cmd_reg.kind)
                    jts_pkg::CMD_OPEN:
                    begin
                        emit_req = !too_deep;
                        emit_ch  = cmd_reg.is_obj ? jts_pkg::CH_LBRACE : jts_pkg::CH_LBRACK;
                    end
                    jts_pkg::CMD_CLOSE:
                    begin
                        emit_req = !bad_close;
                        emit_ch  = cmd_reg.is_obj ? jts_pkg::CH_RBRACE : jts_pkg::CH_RBRACK;
                    end
                    jts_pkg::CMD_TEXT:
                    begin
                        emit_req = cmd_reg.first;
                        emit_ch  = jts_pkg::CH_QUOTE;
                    end
                    jts_pkg::CMD_NUM:
                    begin
                        emit_req = cmd_reg.neg;
                        emit_ch  = jts_pkg::CH_MINUS;
                    end
                    default: emit_req = 1'b0;
                endcase
            end
            jts_pkg::ST_BODY:
            begin
                emit_req = body_go;
                emit_ch  = cmd_reg.body[8*idx_reg +: 8];
            end
            jts_pkg::ST_TAIL:
            begin
                emit_req = (cmd_reg.kind == jts_pkg::CMD_TEXT) && cmd_reg.last;
                emit_ch  = jts_pkg::CH_QUOTE;
            end
            jts_pkg::ST_COLON:
            begin
                emit_req = 1'b1;
                emit_ch  = jts_pkg::CH_COLON;
            end
            jts_pkg::ST_DIGIT:
            begin
                emit_req = 1'b1;
                emit_ch  = jts_pkg::CH_ZERO + {4'h0, bcd_reg[79:76]};
            end
            default: emit_req = 1'b0;
        endcase
    end

    assign advance = !emit_req || !hold_valid_reg || out_free;
    assign emit_ok = !ovf_reg && (stored_reg < capacity);

    always_comb
    begin
        new_res.ch     = emit_ch;
        new_res.valid  = 1'b1;
        new_res.stored = emit_ok;
        new_res.pos    = emit_ok ? stored_reg : 16'd0;
        new_res.ovf    = !emit_ok;
        new_res.req    = (req_reg == 32'hFFFF_FFFF) ? req_reg : req_reg + 32'd1;
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        bcd_next        = bcd_reg;
        bin_next        = bin_reg;
        cnt_next        = cnt_reg;
        dleft_next      = dleft_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        stored_next     = stored_reg;
        req_next        = req_reg;
        ovf_next        = ovf_reg;
        comma_next      = comma_reg;
        depth_next      = depth_reg;
        stack_next      = stack_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        pop             = 1'b0;

        if (advance)
        begin
            if (emit_req)
            begin
                // Push the previous character out and keep the new one back,
                // so the last one of the item can be marked.
                if (hold_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_next       = hold_reg;
                    out_last_next  = 1'b0;
                end
                hold_valid_next = 1'b1;
                hold_next       = new_res;
                req_next        = new_res.req;
                ovf_next        = new_res.ovf;
                if (emit_ok)
                    stored_next = stored_reg + 16'd1;
            end

            case (state_reg)
                jts_pkg::ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        pop        = 1'b1;
                        cmd_next   = q_data;
                        state_next = jts_pkg::ST_SEP;
                    end
                end
                jts_pkg::ST_SEP: state_next = jts_pkg::ST_HEAD;
                jts_pkg::ST_HEAD:
                begin
                    idx_next   = 3'd0;
                    state_next = jts_pkg::ST_END;
                    case (cmd_reg.kind)
                        jts_pkg::CMD_OPEN:
                        begin
                            if (too_deep)
                                ovf_next = 1'b1;
                            else
                            begin
                                stack_next[SIW'(depth_reg)] = cmd_reg.is_obj;
                                depth_next = depth_reg + DEPW'(1);
                                comma_next = 1'b0;
                            end
                        end
                        jts_pkg::CMD_CLOSE:
                        begin
                            if (bad_close)
                                ovf_next = 1'b1;
                            else
                            begin
                                depth_next = depth_reg - DEPW'(1);
                                comma_next = 1'b1;
                            end
                        end
                        jts_pkg::CMD_TEXT, jts_pkg::CMD_RAW, jts_pkg::CMD_LIT:
                            state_next = jts_pkg::ST_BODY;
                        jts_pkg::CMD_NUM:
                        begin
                            bin_next   = cmd_reg.mag;
                            bcd_next   = 80'h0;
                            cnt_next   = 6'd0;
                            state_next = jts_pkg::ST_CONV;
                        end
                        jts_pkg::CMD_RST:
                        begin
                            stored_next = 16'd0;
                            req_next    = 32'd0;
                            depth_next  = '0;
                            ovf_next    = 1'b0;
                            comma_next  = 1'b0;
                        end
                        default: state_next = jts_pkg::ST_END;
                    endcase
                end
                jts_pkg::ST_BODY:
                begin
                    if (!body_go || (idx_reg == cmd_reg.body_len - 3'd1))
                        state_next = jts_pkg::ST_TAIL;
                    else
                        idx_next = idx_reg + 3'd1;
                end
                jts_pkg::ST_TAIL:
                begin
                    state_next = jts_pkg::ST_END;
                    if (cmd_reg.kind == jts_pkg::CMD_LIT)
                        comma_next = 1'b1;
                    else if (cmd_reg.last)
                    begin
                        if (cmd_reg.kind == jts_pkg::CMD_TEXT && cmd_reg.is_key)
                            state_next = jts_pkg::ST_COLON;
                        else
                            comma_next = 1'b1;
                    end
                end
                jts_pkg::ST_COLON:
                begin
                    comma_next = 1'b0;
                    state_next = jts_pkg::ST_END;
                end
                jts_pkg::ST_CONV:
                begin
                    bcd_next = {bcd_adj[78:0], bin_reg[63]};
                    bin_next = {bin_reg[62:0], 1'b0};
                    cnt_next = cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                    begin
                        dleft_next = 5'(jts_pkg::DIGITS);
                        state_next = jts_pkg::ST_SKIP;
                    end
                end
                jts_pkg::ST_SKIP:
                begin
                    // Drop leading zero digits, keep at least one.
                    if (bcd_reg[79:76] == 4'd0 && dleft_reg > 5'd1)
                    begin
                        bcd_next   = {bcd_reg[75:0], 4'h0};
                        dleft_next = dleft_reg - 5'd1;
                    end
                    else
                        state_next = jts_pkg::ST_DIGIT;
                end
                jts_pkg::ST_DIGIT:
                begin
                    bcd_next   = {bcd_reg[75:0], 4'h0};
                    dleft_next = dleft_reg - 5'd1;
                    if (dleft_reg == 5'd1)
                    begin
                        comma_next = 1'b1;
                        state_next = jts_pkg::ST_END;
                    end
                end
                jts_pkg::ST_END:
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_last_next  = 1'b1;
                        if (hold_valid_reg)
                            out_next = hold_reg;
                        else
                        begin
                            out_next     = '0;
                            out_next.ovf = ovf_reg;
                            out_next.req = req_reg;
                        end
                        hold_valid_next = 1'b0;
                        state_next      = jts_pkg::ST_IDLE;
                    end
                end
                default: state_next = jts_pkg::ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= jts_pkg::ST_IDLE;
            hold_valid_reg <= 1'b0;
            stored_reg     <= 16'd0;
            req_reg        <= 32'd0;
            ovf_reg        <= 1'b0;
            comma_reg      <= 1'b0;
            depth_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hold_valid_reg <= hold_valid_next;
            stored_reg     <= stored_next;
            req_reg        <= req_next;
            ovf_reg        <= ovf_next;
            comma_reg      <= comma_next;
            depth_reg      <= depth_next;
            out_valid_reg  <= out_valid_next;
            out_last_reg   <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        idx_reg   <= idx_next;
        bcd_reg   <= bcd_next;
        bin_reg   <= bin_next;
        cnt_reg   <= cnt_next;
        dleft_reg <= dleft_next;
        hold_reg  <= hold_next;
        stack_reg <= stack_next;
        out_reg   <= out_next;
    end

`ifndef SYNTHESIS
    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPW'(MAX_DEPTH))
        else $error("nesting depth beyond limit");

    a_end_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == jts_pkg::ST_END && out_free) |=> (out_valid_reg && out_last_reg))
        else $error("item end did not deliver a last result");

    a_ovf_clear_only_on_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (ovf_reg && !(state_reg == jts_pkg::ST_HEAD && cmd_reg.kind == jts_pkg::CMD_RST))
        |=> ovf_reg)
        else $error("overflow flag cleared without reset command");

    a_hold_before_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == jts_pkg::ST_IDLE) |-> !hold_valid_reg)
        else $error("held character left behind at idle");
`endif

endmodule

// ===== src/json_token_serializer_core.sv =====
// Top level of the JSON token serializer: front end, command queue and back end.
//
//  channel | direction | handshake         | content
//  --------+-----------+-------------------+-----------------------------------------
//  s_*     | in        | s_tvalid/s_tready | one token request per item
//  m_*     | out       | m_tvalid/m_tready | one result per character, or one status
//  cfg_*   | in        | cfg_valid/cfg_ready | output capacity write (always ready)
//
//  The front is combinational; an accepted request waits in a four-entry queue.
//  The back end takes each request through pick-up, separator, head and end steps,
//  plus a body step per body character (at least one), a tail step for text, raw
//  and literal requests and a colon step for a key; a number goes through shifting
//  from binary to decimal, a step per dropped leading zero plus one, one per digit.
//  Reset (rst_n low, asynchronous) clears counters, depth, flags and queue;
//  capacity returns to 4096. Either side may stall at any time; a stalled result
//  holds in the output register, and the back end stops when it next has one to pass on.
module json_token_serializer_core #(
    parameter int MAX_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // tdata: data_byte[7:0], first_char[8], flag_value[9], number[73:10], zero pad
    input  logic [79:0] s_tdata,
    // tuser: op[3:0], has_char[4]
    input  logic [4:0]  s_tuser,
    input  logic        s_tlast,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: out_byte[7:0], stored[8], store_position[24:9], overflowed[25],
    //        required_total[57:26], zero pad
    output logic [63:0] m_tdata,
    // tuser: byte_valid[0]
    output logic        m_tuser,
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] cfg_data,
    input  logic        cfg_valid,
    output logic        cfg_ready
);

    logic [15:0]   cap_reg;
    logic          q_full;
    logic          push;
    jts_pkg::cmd_t push_cmd;
    logic          pop;
    logic          q_valid;
    jts_pkg::cmd_t q_data;
    jts_pkg::res_t res;

    // Capacity register; the user must write it only while idle, the block does not enforce this.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= jts_pkg::CAP_RESET;
        else if (cfg_valid)
            cap_reg <= cfg_data;
    end

    jts_front u_front (
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .op         (s_tuser[3:0]),
        .data_byte  (s_tdata[7:0]),
        .has_char   (s_tuser[4]),
        .first_char (s_tdata[8]),
        .last_char  (s_tlast),
        .flag_value (s_tdata[9]),
        .number     (s_tdata[73:10]),
        .q_full     (q_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    jts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .valid     (q_valid),
        .pop_data  (q_data)
    );

    jts_back #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .capacity  (cap_reg),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res),
        .out_last  (m_tlast)
    );

    // Pack the result fields, lowest first.
    assign m_tdata = {6'd0, res.req, res.ovf, res.pos, res.stored, res.ch};
    assign m_tuser = res.valid;

endmodule
